// File: hdl/fats_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fats_pkg;

  // Message length cap; bytes past it are ignored until the end mark.
  localparam int unsigned MaxMessageBytesDef = 65536;

  // Byte index within a tag: covers a 24-bit payload length plus header and trailer.
  localparam int unsigned TagPosW = 25;

  localparam int unsigned HeaderBytes = 11;
  // Index of the last back-pointer byte relative to the payload length.
  localparam int unsigned TrailerLast = 14;

  localparam logic [7:0] TagAudio   = 8'h08;
  localparam logic [7:0] TagVideo   = 8'h09;
  localparam logic [3:0] CodecAac   = 4'ha;
  localparam logic [3:0] CodecAvc   = 4'h7;
  localparam logic [7:0] AvcSeqByte = 8'h17;

  typedef struct packed {
    logic        is_audio;
    logic [23:0] size;
    logic [31:0] stamp;
    logic [15:0] first_bytes;
    logic [23:0] offset_cap;
    logic [15:0] payload_start;
  } tag_info_t;

  typedef struct packed {
    logic               is_audio;
    logic [31:0]        tag_time;
    logic [15:0]        payload_start;
    logic [23:0]        payload_length;
    logic [3:0]         codec_code;
    logic               setup_needed;
    logic signed [23:0] composition_offset;
  } desc_t;

endpackage

`default_nettype wire

// File: hdl/fats_byte_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module fats_byte_parser #(
  parameter int unsigned MaxMessageBytes = fats_pkg::MaxMessageBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                end_of_message_i,
  output logic                     emit_o,
  output fats_pkg::tag_info_t      info_o
);
  import fats_pkg::*;

  localparam int unsigned MsgPosW = $clog2(MaxMessageBytes + 1);

  logic [MsgPosW-1:0] msg_pos_q, msg_pos_d;
  logic [TagPosW-1:0] tag_pos_q, tag_pos_d;
  logic [7:0]         kind_q, kind_d;
  logic [23:0]        size_q, size_d;
  logic [31:0]        stamp_q, stamp_d;
  logic [15:0]        first_q, first_d;
  logic [23:0]        offset_q, offset_d;

  logic               active;
  logic               tag_end;
  logic [TagPosW-1:0] size_ext;
  logic [TagPosW-1:0] pay_idx;

  assign active   = msg_pos_q < MsgPosW'(MaxMessageBytes);
  assign size_ext = {1'b0, size_q};
  assign tag_end  = tag_pos_q == (size_ext + TagPosW'(TrailerLast));
  assign pay_idx  = tag_pos_q - TagPosW'(HeaderBytes);

  always_comb begin
    msg_pos_d = msg_pos_q;
    tag_pos_d = tag_pos_q;
    kind_d    = kind_q;
    size_d    = size_q;
    stamp_d   = stamp_q;
    first_d   = first_q;
    offset_d  = offset_q;
    if (accept_i && active) begin
      if (tag_pos_q == '0) begin
        kind_d   = data_byte_i;
        size_d   = '0;
        stamp_d  = '0;
        first_d  = '0;
        offset_d = '0;
      end else if (tag_pos_q <= TagPosW'(3)) begin
        size_d = {size_q[15:0], data_byte_i};
      end else if (tag_pos_q <= TagPosW'(6)) begin
        stamp_d[23:0] = {stamp_q[15:0], data_byte_i};
      end else if (tag_pos_q == TagPosW'(7)) begin
        stamp_d[31:24] = data_byte_i;
      end else if (tag_pos_q >= TagPosW'(HeaderBytes) && pay_idx < size_ext) begin
        // capture payload bytes 0..1 and the composition bytes 2..4
        if (pay_idx < TagPosW'(2)) begin
          first_d = {first_q[7:0], data_byte_i};
        end else if (pay_idx < TagPosW'(5)) begin
          offset_d = {offset_q[15:0], data_byte_i};
        end
      end
      tag_pos_d = tag_end ? '0 : tag_pos_q + TagPosW'(1);
      msg_pos_d = msg_pos_q + MsgPosW'(1);
    end
    if (accept_i && end_of_message_i) begin
      msg_pos_d = '0;
      tag_pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_pos_q <= '0;
      tag_pos_q <= '0;
      kind_q    <= '0;
      size_q    <= '0;
      stamp_q   <= '0;
      first_q   <= '0;
      offset_q  <= '0;
    end else begin
      msg_pos_q <= msg_pos_d;
      tag_pos_q <= tag_pos_d;
      kind_q    <= kind_d;
      size_q    <= size_d;
      stamp_q   <= stamp_d;
      first_q   <= first_d;
      offset_q  <= offset_d;
    end
  end

  // Header and payload captures are complete whenever the last trailer byte is due.
  assign emit_o = active && tag_end && (kind_q == TagAudio || kind_q == TagVideo);

  assign info_o.is_audio      = kind_q == TagAudio;
  assign info_o.size          = size_q;
  assign info_o.stamp         = stamp_q;
  assign info_o.first_bytes   = first_q;
  assign info_o.offset_cap    = offset_q;
  assign info_o.payload_start = 16'(msg_pos_q) - size_q[15:0] - 16'd3;

  a_msg_pos_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_pos_q <= MsgPosW'(MaxMessageBytes))
    else $error("message position past cap");

  a_tag_pos_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_pos_q > TagPosW'(3)) |-> (tag_pos_q <= size_ext + TagPosW'(TrailerLast)))
    else $error("tag position ran past the back pointer");

endmodule

`default_nettype wire

// File: hdl/fats_codec_track.sv
`timescale 1ns / 1ps
`default_nettype none

module fats_codec_track (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire fats_pkg::tag_info_t info_i,
  output fats_pkg::desc_t          desc_o
);
  import fats_pkg::*;

  logic [3:0]  prev_audio_q;
  logic [3:0]  prev_video_q;
  logic [23:0] held_q;

  logic        long2;
  logic        long6;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [3:0]  code;
  logic        setup;
  logic [23:0] held_next;

  always_comb begin
    long2 = |info_i.size[23:1];
    long6 = info_i.size >= 24'd6;
    b0    = '0;
    b1    = '0;
    if (long2) begin
      b0 = info_i.first_bytes[15:8];
      b1 = info_i.first_bytes[7:0];
    end else if (info_i.size == 24'd1) begin
      b0 = info_i.first_bytes[7:0];
    end
    held_next = held_q;
    if (info_i.is_audio) begin
      code  = b0[7:4];
      setup = long2 && (prev_audio_q != code || (b1 == 8'h00 && code == CodecAac));
    end else begin
      code  = b0[3:0];
      setup = long2 && (prev_video_q != code || (b1 == 8'h00 && b0 == AvcSeqByte));
      if (code == CodecAvc && long6) begin
        held_next = info_i.offset_cap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_audio_q <= '0;
      prev_video_q <= '0;
      held_q       <= '0;
    end else if (fire_i) begin
      held_q <= held_next;
      if (setup && info_i.is_audio) begin
        prev_audio_q <= code;
      end
      if (setup && !info_i.is_audio) begin
        prev_video_q <= code;
      end
    end
  end

  assign desc_o.is_audio           = info_i.is_audio;
  assign desc_o.tag_time           = info_i.stamp;
  assign desc_o.payload_start      = info_i.payload_start;
  assign desc_o.payload_length     = info_i.size;
  assign desc_o.codec_code         = code;
  assign desc_o.setup_needed       = setup;
  assign desc_o.composition_offset = info_i.is_audio ? 24'sd0 : $signed(held_next);

endmodule

`default_nettype wire

// File: hdl/fats_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module fats_out_skid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fats_pkg::desc_t desc_i,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic                 space_o,
  output fats_pkg::desc_t      desc_o
);
  import fats_pkg::*;

  logic  out_valid_q, out_valid_d;
  logic  skid_valid_q, skid_valid_d;
  desc_t out_q, out_d;
  desc_t skid_q, skid_d;
  logic  pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      // refill from the skid slot first, else from a new request
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = desc_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_d       = desc_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = desc_i;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign space_o     = !skid_valid_q;
  assign desc_o      = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("request pushed into a full output buffer");

endmodule

`default_nettype wire

// File: hdl/flv_aggregate_tag_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// Aggregate-message FLV tag splitter.
// Input channel (in_valid_i / in_ready_o): one message byte per request, with
// end_of_message_i set on the final byte. The byte stream is cut into tags
// (11-byte header, payload, 4-byte back pointer); audio and video tags give one
// descriptor on the output channel (out_valid_o / out_ready_i) when their last
// back-pointer byte is taken. Other tag types, truncated tags and bytes past the
// message cap produce nothing.
// Throughput: one byte per cycle while in_ready_o is high; every byte goes
// through the position counters and capture registers in the cycle it is
// accepted. Output: the descriptor is registered in the output slot, or in the
// skid slot while the output slot is held, and out_valid_o shows it.
// Stall: a two-slot output buffer absorbs one descriptor while the receiver
// holds off; in_ready_o drops only when both slots are full, and bytes keep
// flowing while a descriptor waits in the first slot.
// Reset: clears counters, codec history and the held composition offset; the
// first byte after reset starts a new message.
module flv_aggregate_tag_splitter #(
  parameter int unsigned MaxMessageBytes = fats_pkg::MaxMessageBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               end_of_message_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_audio_o,
  output logic [31:0]             tag_time_o,
  output logic [15:0]             payload_start_o,
  output logic [23:0]             payload_length_o,
  output logic [3:0]              codec_code_o,
  output logic                    setup_needed_o,
  output logic signed [23:0]      composition_offset_o
);
  import fats_pkg::*;

  logic      accept;
  logic      emit;
  logic      fire;
  tag_info_t info;
  desc_t     desc;
  desc_t     desc_out;

  assign accept = in_valid_i && in_ready_o;
  // a descriptor is pushed only by the byte that closes an audio or video tag
  assign fire   = accept && emit;

  fats_byte_parser #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .emit_o          (emit),
    .info_o          (info)
  );

  fats_codec_track u_codec (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .info_i(info),
    .desc_o(desc)
  );

  fats_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .desc_i     (desc),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .space_o    (in_ready_o),
    .desc_o     (desc_out)
  );

  assign is_audio_o           = desc_out.is_audio;
  assign tag_time_o           = desc_out.tag_time;
  assign payload_start_o      = desc_out.payload_start;
  assign payload_length_o     = desc_out.payload_length;
  assign codec_code_o         = desc_out.codec_code;
  assign setup_needed_o       = desc_out.setup_needed;
  assign composition_offset_o = desc_out.composition_offset;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fats_pkg::*;

  // Abort once this many cycles pass with no request moving on either channel.
  localparam int unsigned StallLimit  = 4000;
  // Cycles to watch the output after the last descriptor is checked.
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomBytes = 1250;

  // One directed tag: header fields, the first payload bytes, and how the message ends.
  typedef struct {
    logic [7:0]  kind;
    logic [23:0] len;
    logic [31:0] stamp;
    logic [39:0] lead;      // payload bytes 0..4, byte 0 in the top bits
    int          cut;       // bytes sent before a forced message end; 0 sends the whole tag
    bit          last_tag;  // mark the final back-pointer byte as message end
    bit          typed;     // descriptor below is compared as written
    desc_t       want;
  } tag_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_mark = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        o_is_audio;
  logic [31:0] o_tag_time;
  logic [15:0] o_payload_start;
  logic [23:0] o_payload_length;
  logic [3:0]  o_codec_code;
  logic        o_setup_needed;
  logic signed [23:0] o_composition;
  desc_t       seen;

  assign seen = {o_is_audio, o_tag_time, o_payload_start, o_payload_length,
                 o_codec_code, o_setup_needed, o_composition};

  flv_aggregate_tag_splitter dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .data_byte_i         (data_byte),
    .end_of_message_i    (end_mark),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .is_audio_o          (o_is_audio),
    .tag_time_o          (o_tag_time),
    .payload_start_o     (o_payload_start),
    .payload_length_o    (o_payload_length),
    .codec_code_o        (o_codec_code),
    .setup_needed_o      (o_setup_needed),
    .composition_offset_o(o_composition)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parser state mirrored from the block's behavior.
  int unsigned msg_pos = 0;
  int unsigned tag_pos = 0;
  logic [7:0]  t_kind = '0;
  logic [23:0] t_size = '0;
  logic [31:0] t_stamp = '0;
  logic [15:0] t_first = '0;
  logic [23:0] t_offs = '0;
  logic [23:0] held_comp = '0;
  logic [3:0]  prev_audio = '0;
  logic [3:0]  prev_video = '0;

  desc_t pending_desc[$];
  bit    use_typed = 1'b0;
  desc_t typed_desc = '0;
  int    tx_idle = 0;
  int    rx_idle = 0;
  int    errors = 0;
  int    byte_count = 0;
  int    msg_count = 0;
  int    desc_count = 0;
  int    quiet_cycles = 0;

  tag_row_t dir_rows [22] = '{
    // AAC sequence header right after reset: codec differs from the cleared history
    '{TagAudio, 24'd2, 32'h0000_0000, 40'hAF00_0000_00, 0, 1'b0, 1'b1,
      '{1'b1, 32'h0000_0000, 16'd11, 24'd2, 4'hA, 1'b1, 24'sd0}},
    // same codec, not a sequence header: no setup; timestamp all ones
    '{TagAudio, 24'd2, 32'hFFFF_FFFF, 40'hAF01_0000_00, 0, 1'b0, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 16'd28, 24'd2, 4'hA, 1'b0, 24'sd0}},
    // AVC with a payload too short to reload the composition offset
    '{TagVideo, 24'd5, 32'h0012_3456, 40'h1700_1122_33, 0, 1'b0, 1'b1,
      '{1'b0, 32'h0012_3456, 16'd45, 24'd5, 4'h7, 1'b1, 24'sd0}},
    // reload with a small negative offset, then the most negative one
    '{TagVideo, 24'd6, 32'h0100_0000, 40'h2701_FFFF_FE, 0, 1'b0, 1'b0, '0},
    '{TagVideo, 24'd6, 32'h0000_0001, 40'h1700_8000_00, 0, 1'b0, 1'b0, '0},
    // empty and one-byte payloads keep the held offset
    '{TagVideo, 24'd0, 32'h0000_0002, 40'h0, 0, 1'b0, 1'b0, '0},
    '{TagVideo, 24'd1, 32'h0000_0003, 40'h1200_0000_00, 0, 1'b0, 1'b0, '0},
    // most positive offset
    '{TagVideo, 24'd7, 32'h00FF_FFFF, 40'h2701_7FFF_FF, 0, 1'b0, 1'b0, '0},
    // other tag types are skipped
    '{8'h12, 24'd4, 32'h0000_0004, 40'h0102_0304_00, 0, 1'b0, 1'b0, '0},
    '{8'hFF, 24'd0, 32'h0000_0005, 40'h0, 0, 1'b0, 1'b0, '0},
    '{TagAudio, 24'd1, 32'h0000_0006, 40'h2000_0000_00, 0, 1'b0, 1'b0, '0},
    // codec change; the message ends on the last back-pointer byte
    '{TagAudio, 24'd3, 32'h0000_0007, 40'h2F00_0000_00, 0, 1'b1, 1'b0, '0},
    // truncated in the header, in the back pointer, and a one-byte message
    '{TagVideo, 24'd3, 32'h0000_0008, 40'h1700_0000_00, 10, 1'b0, 1'b0, '0},
    '{TagAudio, 24'd3, 32'h0000_0009, 40'hAF00_0000_00, 17, 1'b0, 1'b0, '0},
    '{TagAudio, 24'd0, 32'h0000_000A, 40'h0, 1, 1'b0, 1'b0, '0},
    // back to AAC, then an AAC sequence header on an unchanged codec
    '{TagAudio, 24'd2, 32'h0000_0001, 40'hAF01_0000_00, 0, 1'b1, 1'b1,
      '{1'b1, 32'h0000_0001, 16'd11, 24'd2, 4'hA, 1'b1, 24'sd0}},
    '{TagAudio, 24'd2, 32'h8000_0000, 40'hAF00_0000_00, 0, 1'b1, 1'b1,
      '{1'b1, 32'h8000_0000, 16'd11, 24'd2, 4'hA, 1'b1, 24'sd0}},
    // largest payload length, cut short
    '{TagVideo, 24'hFF_FFFF, 32'h0000_0000, 40'h0, 20, 1'b0, 1'b0, '0},
    '{TagVideo, 24'd60, 32'h7FFF_FFFF, 40'h1F00_0000_00, 0, 1'b1, 1'b0, '0},
    '{TagAudio, 24'd2, 32'h00AB_CDEF, 40'hF000_0000_00, 0, 1'b1, 1'b0, '0},
    // a full tag followed by a remainder shorter than a tag
    '{TagAudio, 24'd2, 32'h0000_0010, 40'hAF01_0000_00, 0, 1'b0, 1'b0, '0},
    '{TagAudio, 24'd0, 32'h0000_0011, 40'h0, 9, 1'b0, 1'b0, '0}
  };

  // Advance the mirrored parser by one accepted byte; return the descriptor it causes.
  task automatic track_tag_byte(input logic [7:0] b, input bit last,
                                output bit emit, output desc_t d);
    int unsigned tp;
    int unsigned p;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [3:0]  code;
    logic [31:0] start;
    emit = 1'b0;
    d = '0;
    if (msg_pos < MaxMessageBytesDef) begin
      tp = tag_pos;
      if (tp == 0) begin
        t_kind = b;
        t_size = '0;
        t_stamp = '0;
        t_first = '0;
        t_offs = '0;
      end else if (tp <= 3) begin
        t_size = {t_size[15:0], b};
      end else if (tp <= 6) begin
        t_stamp[23:0] = {t_stamp[15:0], b};
      end else if (tp == 7) begin
        t_stamp[31:24] = b;
      end else if (tp >= HeaderBytes && tp - HeaderBytes < t_size) begin
        p = tp - HeaderBytes;
        if (p < 2) t_first = {t_first[7:0], b};
        else if (p < 5) t_offs = {t_offs[15:0], b};
      end
      if (tp == t_size + TrailerLast) begin
        if (t_kind == TagAudio || t_kind == TagVideo) begin
          emit = 1'b1;
          b0 = '0;
          b1 = '0;
          if (t_size >= 2) begin
            b0 = t_first[15:8];
            b1 = t_first[7:0];
          end else if (t_size == 1) begin
            b0 = t_first[7:0];
          end
          d.is_audio = (t_kind == TagAudio);
          if (d.is_audio) begin
            code = b0[7:4];
            if (t_size >= 2 && (prev_audio != code || (b1 == 0 && code == CodecAac))) begin
              d.setup_needed = 1'b1;
              prev_audio = code;
            end
          end else begin
            code = b0[3:0];
            if (t_size >= 2 && (prev_video != code || (b1 == 0 && b0 == AvcSeqByte))) begin
              d.setup_needed = 1'b1;
              prev_video = code;
            end
            if (code == CodecAvc && t_size >= 6) held_comp = t_offs;
            d.composition_offset = held_comp;
          end
          start = msg_pos - t_size - (TrailerLast - HeaderBytes);
          d.tag_time = t_stamp;
          d.payload_start = start[15:0];
          d.payload_length = t_size;
          d.codec_code = code;
        end
        tag_pos = 0;
      end else begin
        tag_pos = tp + 1;
      end
      msg_pos++;
    end
    if (last) begin
      msg_pos = 0;
      tag_pos = 0;
    end
  endtask

  // Offer one byte, idling first at the current rate; hold it until the request is taken.
  task automatic send_byte(input logic [7:0] b, input bit last);
    bit    emit;
    desc_t d;
    while ($urandom_range(99, 0) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_mark <= last;
    do @(posedge clk); while (!in_ready);
    track_tag_byte(b, last, emit, d);
    if (emit) pending_desc.push_back(use_typed ? typed_desc : d);
    byte_count++;
    if (last) msg_count++;
  endtask

  // Serialize one tag: header, payload, back pointer. A nonzero cut ends the message early.
  task automatic send_tag(input logic [7:0] kind, input logic [23:0] len,
                          input logic [31:0] stamp, input logic [39:0] lead,
                          input int cut, input bit last_tag);
    int total;
    int n;
    int p;
    logic [7:0] b;
    total = int'(len) + TrailerLast + 1;
    n = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < n; i++) begin
      p = i - int'(HeaderBytes);
      case (i)
        0: b = kind;
        1: b = len[23:16];
        2: b = len[15:8];
        3: b = len[7:0];
        4: b = stamp[23:16];
        5: b = stamp[15:8];
        6: b = stamp[7:0];
        7: b = stamp[31:24];
        default: b = (p >= 0 && p < 5) ? lead[39 - 8 * p -: 8] : 8'($urandom);
      endcase
      send_byte(b, i == n - 1 && (cut > 0 || last_tag));
    end
  endtask

  // Mostly well-formed messages of audio and video tags; some noise and broken endings.
  task automatic send_random_message();
    int n;
    int m;
    int r;
    int total;
    logic [7:0]  kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [23:0] len;
    logic [39:0] lead;
    if ($urandom_range(99, 0) < 12) begin
      // raw bytes with no tag structure
      n = $urandom_range(40, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
    end else begin
      n = $urandom_range(6, 1);
      for (int t = 0; t < n; t++) begin
        r = $urandom_range(99, 0);
        kind = (r < 45) ? TagAudio : (r < 88) ? TagVideo : 8'($urandom);
        r = $urandom_range(99, 0);
        len = (r < 70) ? 24'($urandom_range(8, 0)) :
              (r < 95) ? 24'($urandom_range(60, 9)) : 24'($urandom_range(300, 61));
        // bias the codec byte toward AAC and AVC so that setup and reload paths fire
        r = $urandom_range(99, 0);
        if (kind == TagAudio) begin
          b0 = (r < 40) ? {CodecAac, 4'hF} : (r < 65) ? 8'h2F : 8'($urandom);
        end else begin
          b0 = (r < 35) ? AvcSeqByte : (r < 65) ? {4'h2, CodecAvc} : 8'($urandom);
        end
        b1 = $urandom_range(1, 0) ? 8'h00 : 8'($urandom);
        lead = {b0, b1, 24'($urandom)};
        if (t < n - 1) begin
          send_tag(kind, len, $urandom, lead, 0, 1'b0);
        end else begin
          r = $urandom_range(99, 0);
          total = int'(len) + TrailerLast + 1;
          if (r < 4) begin
            // arbitrary header length: cut short unless the whole tag fits within the cut
            send_tag(kind, 24'($urandom), $urandom, lead, $urandom_range(40, 1), 1'b0);
          end else if (r < 24) begin
            send_tag(kind, len, $urandom, lead, $urandom_range(total, 1), 1'b0);
          end else if (r < 34) begin
            send_tag(kind, len, $urandom, lead, 0, 1'b0);
            m = $urandom_range(14, 1);
            for (int i = 0; i < m; i++) send_byte(8'($urandom), i == m - 1);
          end else begin
            send_tag(kind, len, $urandom, lead, 0, 1'b1);
          end
        end
      end
    end
  endtask

  // Check descriptors in order, toggle the receiver's ready, and watch for a hang.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    desc_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_desc.size() == 0) begin
          $display("%0t: descriptor with none expected: expected nothing got %p", $time, seen);
          errors++;
        end else begin
          want = pending_desc.pop_front();
          check_field("is_audio", 32'(want.is_audio), 32'(seen.is_audio));
          check_field("tag_time", want.tag_time, seen.tag_time);
          check_field("payload_start", 32'(want.payload_start), 32'(seen.payload_start));
          check_field("payload_length", 32'(want.payload_length), 32'(seen.payload_length));
          check_field("codec_code", 32'(want.codec_code), 32'(seen.codec_code));
          check_field("setup_needed", 32'(want.setup_needed), 32'(seen.setup_needed));
          check_field("composition_offset", 32'(unsigned'(want.composition_offset)),
                      32'(unsigned'(seen.composition_offset)));
        end
        desc_count++;
      end
      out_ready <= ($urandom_range(99, 0) >= rx_idle);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no request moved for %0d cycles, %0d descriptors outstanding",
                 $time, StallLimit, pending_desc.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int rand_base;
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first stretch: sender idles a little, receiver a lot
    tx_idle = 24;
    rx_idle = 72;
    foreach (dir_rows[i]) begin
      use_typed = dir_rows[i].typed;
      typed_desc = dir_rows[i].want;
      send_tag(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].stamp, dir_rows[i].lead,
               dir_rows[i].cut, dir_rows[i].last_tag);
      use_typed = 1'b0;
    end

    rand_base = byte_count;
    phase = 0;
    while (byte_count - rand_base < RandomBytes) begin
      if (phase == 0 && byte_count - rand_base >= RandomBytes / 3) begin
        // hold the sender until every outstanding descriptor has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_desc.size() != 0);
        tx_idle = 72;
        rx_idle = 24;
        phase = 1;
      end else if (phase == 1 && byte_count - rand_base >= 2 * RandomBytes / 3) begin
        tx_idle = 0;
        rx_idle = 0;
        phase = 2;
      end
      send_random_message();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_desc.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("tb: %0d bytes in %0d messages, %0d descriptors checked, %0d mismatches",
             byte_count, msg_count, desc_count, errors);
    $display("tb: covered skipped types, truncation, short remainders and codec setup paths");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/fats_pkg.sv
hdl/fats_byte_parser.sv
hdl/fats_codec_track.sv
hdl/fats_out_skid.sv
hdl/flv_aggregate_tag_splitter.sv
tb/tb.sv
